// ----- src/rsr_pkg.sv -----
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared widths, limits and types of the replacement-selection run generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rsr_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 32;
  localparam int RUN_W = 16;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  // running best candidate of the minimum search
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } best_t;

endpackage

`default_nettype wire

// ----- src/rsr_if.sv -----
// ----------------------------------------------------------------------------
// rsr_if
// Valid/ready channels for input records and emitted run records.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsr_in_if;
  logic                      valid;
  logic                      ready;
  logic [rsr_pkg::KEY_W-1:0] record_key;
  logic [rsr_pkg::TAG_W-1:0] record_tag;
  logic                      input_last;

  modport source (output valid, output record_key, output record_tag, output input_last,
                  input ready);
  modport sink   (input valid, input record_key, input record_tag, input input_last,
                  output ready);
endinterface

interface rsr_out_if;
  logic                      valid;
  logic                      ready;
  logic [rsr_pkg::KEY_W-1:0] out_key;
  logic [rsr_pkg::TAG_W-1:0] out_tag;
  logic                      run_end;
  logic [rsr_pkg::RUN_W-1:0] run_number;
  logic                      stream_last;

  modport source (output valid, output out_key, output out_tag, output run_end,
                  output run_number, output stream_last, input ready);
  modport sink   (input valid, input out_key, input out_tag, input run_end,
                  input run_number, input stream_last, output ready);
endinterface

`default_nettype wire

// ----- src/rsr_slot_mem.sv -----
// ----------------------------------------------------------------------------
// rsr_slot_mem
// Key and tag storage of the record slots, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rsr_slot_mem #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [IDX_W-1:0]          waddr,
  input  wire logic [rsr_pkg::KEY_W-1:0] wkey,
  input  wire logic [rsr_pkg::TAG_W-1:0] wtag,
  input  wire logic [IDX_W-1:0]          raddr,
  output logic      [rsr_pkg::KEY_W-1:0] rkey,
  output logic      [rsr_pkg::TAG_W-1:0] rtag
);

  logic [rsr_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic [rsr_pkg::TAG_W-1:0] tag_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      tag_mem[waddr] <= wtag;
    end
  end

  always_ff @(posedge clk) begin
    rkey <= key_mem[raddr];
    rtag <= tag_mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/rsr_min_unit.sv -----
// ----------------------------------------------------------------------------
// rsr_min_unit
// Shared unsigned key comparator with the running minimum of a slot scan.
// ----------------------------------------------------------------------------
`default_nettype none

module rsr_min_unit #(
  parameter int IDX_W = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      clr,
  input  wire logic                      cand_en,
  input  wire logic [IDX_W-1:0]          cand_idx,
  input  wire logic [rsr_pkg::KEY_W-1:0] cand_key,
  input  wire logic [rsr_pkg::TAG_W-1:0] cand_tag,
  output logic                           lt,
  output rsr_pkg::best_t                 best,
  output logic      [IDX_W-1:0]          best_idx
);

  rsr_pkg::best_t   best_r, best_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // strict compare keeps the lowest slot on ties
  assign lt = cand_key < best_r.key;

  always_comb begin
    best_nxt = best_r;
    idx_nxt  = idx_r;
    if (clr) begin
      best_nxt.vld = 1'b0;
    end else if (cand_en && (!best_r.vld || lt)) begin
      best_nxt.vld = 1'b1;
      best_nxt.key = cand_key;
      best_nxt.tag = cand_tag;
      idx_nxt      = cand_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r.vld <= 1'b0;
    end else begin
      best_r.vld <= best_nxt.vld;
    end
    best_r.key <= best_nxt.key;
    best_r.tag <= best_nxt.tag;
    idx_r      <= idx_nxt;
  end

  assign best     = best_r;
  assign best_idx = idx_r;

endmodule

`default_nettype wire

// ----- src/replacement_selection_runs.sv -----
// ----------------------------------------------------------------------------
// replacement_selection_runs
// Sorted-run generator by replacement selection over SLOTS buffered records.
// ----------------------------------------------------------------------------
// while the buffer fills a record goes to a free slot with no beat out; when it is full
//   an accepted record starts a scan of all slots through the memory read port and the
//   comparator, then an emit sends the minimum and stores the record in its slot, and no
//   record is taken before that; each drained record after end of input costs another
//   scan and emit; results leave through an output register; a stall holds the emit cycle
// synchronous reset clears control, occupancy and freeze bits; slot memory is not cleared
`default_nettype none

module replacement_selection_runs #(
  parameter int SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rsr_in_if.sink    in_if,
  rsr_out_if.source out_if
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic [CNT_W-1:0]          scan_r, scan_nxt;
  logic [rsr_pkg::RUN_W-1:0] run_r, run_nxt, run_inc;
  logic [SLOTS-1:0]          occ_r, occ_nxt, occ_tmp;
  logic [SLOTS-1:0]          frz_r, frz_nxt, frz_tmp;
  logic                      drain_r, drain_nxt;
  logic                      last_r, last_nxt;
  logic [rsr_pkg::KEY_W-1:0] nkey_r, nkey_nxt;
  logic [rsr_pkg::TAG_W-1:0] ntag_r, ntag_nxt;
  logic                      live;

  logic                      out_vld_r;
  logic [rsr_pkg::KEY_W-1:0] out_key_r;
  logic [rsr_pkg::TAG_W-1:0] out_tag_r;
  logic                      out_end_r, out_slast_r;
  logic [rsr_pkg::RUN_W-1:0] out_run_r;
  logic                      out_load, out_end, out_slast, out_free;

  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr, mem_raddr;
  logic [rsr_pkg::KEY_W-1:0] mem_wkey, mem_rkey;
  logic [rsr_pkg::TAG_W-1:0] mem_wtag, mem_rtag;

  logic                      clr, cand_en, lt;
  logic [IDX_W-1:0]          cand_idx, best_idx;
  logic [rsr_pkg::KEY_W-1:0] cand_key;
  rsr_pkg::best_t            best;

  logic                      in_fire;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_vld_r || out_if.ready;
  assign run_inc     = (run_r == rsr_pkg::RUN_MAX) ? run_r :
                       run_r + {{(rsr_pkg::RUN_W-1){1'b0}}, 1'b1};

  // data read at scan step n belongs to slot n-1
  assign mem_raddr = (scan_r == SLOTS_C) ? '0 : scan_r[IDX_W-1:0];
  assign cand_idx  = IDX_W'(scan_r - CNT_W'(1));
  assign cand_en   = (state_r == S_SCAN) && (scan_r != '0) &&
                     occ_r[cand_idx] && !frz_r[cand_idx];
  // the emit cycle reuses the comparator for the freeze decision
  assign cand_key  = (state_r == S_EMIT) ? nkey_r : mem_rkey;

  rsr_slot_mem #(
    .DEPTH (SLOTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wkey  (mem_wkey),
    .wtag  (mem_wtag),
    .raddr (mem_raddr),
    .rkey  (mem_rkey),
    .rtag  (mem_rtag)
  );

  rsr_min_unit #(
    .IDX_W (IDX_W)
  ) u_min (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (clr),
    .cand_en  (cand_en),
    .cand_idx (cand_idx),
    .cand_key (cand_key),
    .cand_tag (mem_rtag),
    .lt       (lt),
    .best     (best),
    .best_idx (best_idx)
  );

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    scan_nxt  = scan_r;
    run_nxt   = run_r;
    occ_nxt   = occ_r;
    frz_nxt   = frz_r;
    drain_nxt = drain_r;
    last_nxt  = last_r;
    nkey_nxt  = nkey_r;
    ntag_nxt  = ntag_r;
    occ_tmp   = occ_r;
    frz_tmp   = frz_r;
    live      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = best_idx;
    mem_wkey  = nkey_r;
    mem_wtag  = ntag_r;
    clr       = 1'b0;
    out_load  = 1'b0;
    out_end   = 1'b0;
    out_slast = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          nkey_nxt = in_if.record_key;
          ntag_nxt = in_if.record_tag;
          last_nxt = in_if.input_last;
          if (fill_r < SLOTS_C) begin
            mem_we    = 1'b1;
            mem_waddr = fill_r[IDX_W-1:0];
            mem_wkey  = in_if.record_key;
            mem_wtag  = in_if.record_tag;
            occ_nxt[fill_r[IDX_W-1:0]] = 1'b1;
            frz_nxt[fill_r[IDX_W-1:0]] = 1'b0;
            fill_nxt = fill_r + CNT_W'(1);
            if (in_if.input_last) begin
              drain_nxt = 1'b1;
              clr       = 1'b1;
              scan_nxt  = '0;
              state_nxt = S_SCAN;
            end
          end else begin
            drain_nxt = 1'b0;
            clr       = 1'b1;
            scan_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        scan_nxt = scan_r + CNT_W'(1);
        if (scan_r == SLOTS_C) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!best.vld) begin
          if (drain_r) begin
            fill_nxt  = '0;
            run_nxt   = '0;
            occ_nxt   = '0;
            frz_nxt   = '0;
            drain_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            // nothing unfrozen with a full buffer: close the run and rescan
            frz_nxt   = '0;
            run_nxt   = run_inc;
            clr       = 1'b1;
            scan_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end else if (out_free) begin
          out_load = 1'b1;
          if (!drain_r) begin
            mem_we            = 1'b1;
            frz_tmp[best_idx] = lt;
            live              = |(occ_r & ~frz_tmp);
            out_end           = !live;
            if (!live) begin
              frz_tmp = '0;
              run_nxt = run_inc;
            end
            frz_nxt = frz_tmp;
            if (last_r) begin
              drain_nxt = 1'b1;
              clr       = 1'b1;
              scan_nxt  = '0;
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            occ_tmp[best_idx] = 1'b0;
            frz_tmp[best_idx] = 1'b0;
            live              = |(occ_tmp & ~frz_tmp);
            out_end           = !live;
            out_slast         = (occ_tmp == '0);
            if (out_slast) begin
              fill_nxt  = '0;
              run_nxt   = '0;
              occ_nxt   = '0;
              frz_nxt   = '0;
              drain_nxt = 1'b0;
              state_nxt = S_IDLE;
            end else begin
              if (!live) begin
                frz_tmp = '0;
                run_nxt = run_inc;
              end
              occ_nxt   = occ_tmp;
              frz_nxt   = frz_tmp;
              clr       = 1'b1;
              scan_nxt  = '0;
              state_nxt = S_SCAN;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      scan_r    <= '0;
      run_r     <= '0;
      occ_r     <= '0;
      frz_r     <= '0;
      drain_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      scan_r    <= scan_nxt;
      run_r     <= run_nxt;
      occ_r     <= occ_nxt;
      frz_r     <= frz_nxt;
      drain_r   <= drain_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    nkey_r <= nkey_nxt;
    ntag_r <= ntag_nxt;
    if (out_load) begin
      out_key_r   <= best.key;
      out_tag_r   <= best.tag;
      out_end_r   <= out_end;
      out_run_r   <= run_r;
      out_slast_r <= out_slast;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.out_key     = out_key_r;
  assign out_if.out_tag     = out_tag_r;
  assign out_if.run_end     = out_end_r;
  assign out_if.run_number  = out_run_r;
  assign out_if.stream_last = out_slast_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= SLOTS_C)
    else $error("fill count beyond slot count");

  a_frozen_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (frz_r & ~occ_r) == '0)
    else $error("frozen bit on an empty slot");

  a_fill_unfrozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && fill_r < SLOTS_C) |-> frz_r == '0)
    else $error("frozen slot while buffer still filling");

  a_last_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_slast |=> out_end_r && out_vld_r && fill_r == '0 && occ_r == '0)
    else $error("final beat did not close the run and empty the buffer");

  a_replace_has_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !drain_r) |-> best.vld)
    else $error("no unfrozen slot found with a full buffer");
`endif

endmodule

`default_nettype wire

// ----- tb/rsr_run_checker.sv -----
// ----------------------------------------------------------------------------
// rsr_run_checker
// Watches the record and run channels, predicts every emitted run record
// from the accepted input beats and compares field by field in order.
// ----------------------------------------------------------------------------
module rsr_run_checker #(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  rsr_in_if    in_mon,
  rsr_out_if   out_mon,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [rsr_pkg::KEY_W-1:0] key;
    logic [rsr_pkg::TAG_W-1:0] tag;
    logic                      run_end;
    logic [rsr_pkg::RUN_W-1:0] run_number;
    logic                      stream_last;
  } run_rec_t;

  logic [rsr_pkg::KEY_W-1:0] slot_key [SLOTS];
  logic [rsr_pkg::TAG_W-1:0] slot_tag [SLOTS];
  bit                        slot_cold [SLOTS];
  bit                        slot_used [SLOTS];
  int unsigned               filled;
  logic [rsr_pkg::RUN_W-1:0] run_idx;
  run_rec_t                  due_recs [$];
  int                        err_total = 0;

  // smallest unfrozen occupied key, lowest slot on ties
  function automatic int lowest_live_slot();
    int best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && !slot_cold[i] && (best < 0 || slot_key[i] < slot_key[best]))
        best = i;
    return best;
  endfunction

  // run closes once nothing occupied is left unfrozen
  function automatic bit seal_run();
    if (lowest_live_slot() >= 0) return 1'b0;
    for (int i = 0; i < SLOTS; i++) slot_cold[i] = 1'b0;
    if (run_idx != rsr_pkg::RUN_MAX) run_idx++;
    return 1'b1;
  endfunction

  function automatic run_rec_t take_slot(int s);
    run_rec_t r;
    r.key         = slot_key[s];
    r.tag         = slot_tag[s];
    r.run_end     = 1'b0;
    r.run_number  = run_idx;
    r.stream_last = 1'b0;
    return r;
  endfunction

  task automatic absorb_record(input logic [rsr_pkg::KEY_W-1:0] key,
                               input logic [rsr_pkg::TAG_W-1:0] tag,
                               input logic last);
    run_rec_t                  r;
    run_rec_t                  batch [$];
    int                        s;
    logic [rsr_pkg::KEY_W-1:0] gone;
    if (filled < SLOTS) begin
      s = filled;
      slot_key[s]  = key;
      slot_tag[s]  = tag;
      slot_cold[s] = 1'b0;
      slot_used[s] = 1'b1;
      filled++;
    end else begin
      s = lowest_live_slot();
      if (s < 0) begin
        void'(seal_run());
        s = lowest_live_slot();
      end
      if (s >= 0) begin
        r = take_slot(s);
        gone = slot_key[s];
        slot_key[s]  = key;
        slot_tag[s]  = tag;
        slot_cold[s] = key < gone;
        r.run_end = seal_run();
        batch.push_back(r);
      end
    end
    if (last) begin
      s = lowest_live_slot();
      while (s >= 0) begin
        r = take_slot(s);
        slot_used[s] = 1'b0;
        slot_cold[s] = 1'b0;
        r.run_end = seal_run();
        batch.push_back(r);
        s = lowest_live_slot();
      end
      if (batch.size() > 0) batch[batch.size()-1].stream_last = 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
        slot_cold[i] = 1'b0;
        slot_used[i] = 1'b0;
      end
      filled  = 0;
      run_idx = '0;
    end
    foreach (batch[i]) due_recs.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    run_rec_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_cold[i] = 1'b0;
        slot_used[i] = 1'b0;
      end
      filled  = 0;
      run_idx = '0;
      due_recs.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        absorb_record(in_mon.record_key, in_mon.record_tag, in_mon.input_last);
      if (out_mon.valid && out_mon.ready) begin
        if (due_recs.size() == 0) begin
          $error("unexpected run beat: key %h tag %h", out_mon.out_key, out_mon.out_tag);
          err_total++;
        end else begin
          want = due_recs.pop_front();
          if (out_mon.out_key !== want.key) begin
            $error("out_key: expected %h, got %h", want.key, out_mon.out_key);
            err_total++;
          end
          if (out_mon.out_tag !== want.tag) begin
            $error("out_tag: expected %h, got %h", want.tag, out_mon.out_tag);
            err_total++;
          end
          if (out_mon.run_end !== want.run_end) begin
            $error("run_end: expected %b, got %b", want.run_end, out_mon.run_end);
            err_total++;
          end
          if (out_mon.run_number !== want.run_number) begin
            $error("run_number: expected %0d, got %0d", want.run_number, out_mon.run_number);
            err_total++;
          end
          if (out_mon.stream_last !== want.stream_last) begin
            $error("stream_last: expected %b, got %b", want.stream_last, out_mon.stream_last);
            err_total++;
          end
        end
      end
    end
    mismatches  <= err_total;
    outstanding <= due_recs.size();
  end

endmodule

// ----- tb/replacement_selection_runs_tb.sv -----
// ----------------------------------------------------------------------------
// replacement_selection_runs_tb
// Drives record streams of assorted length and key shape into the run
// generator with bursty input and a stalling output; the checker predicts
// and compares every run beat, this module gives the verdict.
// ----------------------------------------------------------------------------
module replacement_selection_runs_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 16;
  localparam int RANDOM_ITEMS = 180;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 2 * (SLOTS + 2);

  typedef enum int {SHAPE_WIDE, SHAPE_NARROW, SHAPE_RISING, SHAPE_FALLING} key_shape_e;
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_BURSTY, SINK_SPARSE} sink_style_e;

  logic clk = 1'b0;
  logic rst_n;

  rsr_in_if  in_if ();
  rsr_out_if out_if ();

  int          mismatches;
  int          outstanding;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic [15:0] sink_tick = '0;
  sink_style_e sink_style = SINK_OPEN;

  logic [31:0] fill_keys [SLOTS] = '{32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'd7, 32'd7, 32'd1,
                                     32'd2, 32'd3, 32'd100, 32'd100, 32'd9, 32'd8, 32'd55,
                                     32'd4000, 32'd6, 32'd5};

  always #10 clk = ~clk;

  replacement_selection_runs #(.SLOTS(SLOTS)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  rsr_run_checker #(.SLOTS(SLOTS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // output side stalls on its own rhythm, style redrawn at random when sink_tick[6:0] is zero
  always @(posedge clk) begin
    sink_tick <= sink_tick + 16'd1;
    if (sink_tick[6:0] == 7'd0) sink_style <= sink_style_e'($urandom_range(0, 3));
    case (sink_style)
      SINK_OPEN:   out_if.ready <= 1'b1;
      SINK_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
      SINK_BURSTY: out_if.ready <= (sink_tick[3:0] < 4'd11);
      default:     out_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic put_record(input logic [31:0] key, input logic [31:0] tag, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.record_key <= key;
    in_if.record_tag <= tag;
    in_if.input_last <= last;
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // sender holds off until every predicted run beat has come out
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_stream(input int len, input key_shape_e shape);
    logic [31:0] base;
    logic [31:0] step;
    logic [31:0] key;
    base = $urandom();
    step = $urandom_range(1, 1000);
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_WIDE:    key = $urandom();
        SHAPE_NARROW:  key = $urandom_range(0, 7);
        SHAPE_RISING:  key = base + step * i + $urandom_range(0, 3);
        default:       key = base - step * i;
      endcase
      put_record(key, $urandom(), i == len - 1);
    end
  endtask

  initial begin
    int sent;
    int len;
    in_if.valid      <= 1'b0;
    in_if.record_key <= '0;
    in_if.record_tag <= '0;
    in_if.input_last <= 1'b0;
    rst_n            <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // one-record stream: stored then drained alone
    put_record(32'hFFFF_FFFF, 32'h0, 1'b1);
    // last record while filling, equal keys drain lowest slot first
    put_record(32'd5, 32'd1, 1'b0);
    put_record(32'd5, 32'd2, 1'b0);
    put_record(32'd0, 32'hFFFF_FFFF, 1'b1);
    // full buffer, then a larger key, a frozen key, an equal key and the end
    for (int i = 0; i < SLOTS; i++)
      put_record(fill_keys[i], 32'hC0DE_0000 + i, 1'b0);
    put_record(32'd5, 32'h0000_0100, 1'b0);
    put_record(32'd0, 32'h0000_0101, 1'b0);
    put_record(32'd2, 32'h0000_0102, 1'b0);
    put_record(32'hFFFF_FFFF, 32'h0000_0103, 1'b1);
    hold_until_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, SLOTS) : $urandom_range(SLOTS + 1, 48);
      if ($urandom_range(0, 3) == 0) hold_until_drained();
      send_stream(len, key_shape_e'($urandom_range(0, 3)));
      sent += len;
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/rsr_pkg.sv
src/rsr_if.sv
src/rsr_slot_mem.sv
src/rsr_min_unit.sv
src/replacement_selection_runs.sv
tb/rsr_run_checker.sv
tb/replacement_selection_runs_tb.sv
